// ----- src/kfsw_pkg.sv -----
package kfsw_pkg;

  // Window depth of the estimator; the configured window limit is clamped to it.
  localparam int WINDOW_DEPTH = 32;

  localparam int STAMP_W  = 48;
  localparam int POS_W    = 32;
  localparam int QUAT_W   = 16;
  localparam int INDEX_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int REASON_W = 3;

  localparam int INTV_W   = 32;
  localparam int DIST_W   = 63;
  localparam int COS_W    = 15;
  localparam int CFG_W    = 63;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW   = 3'd4;

  localparam logic [INTV_W-1:0]  RST_MIN_INTERVAL = 32'd100000;
  localparam logic [INTV_W-1:0]  RST_MAX_INTERVAL = 32'd1000000;
  localparam logic [DIST_W-1:0]  RST_MIN_DIST_SQ  = 63'd1048576;
  localparam logic [COS_W-1:0]   RST_COS_HALF     = 15'd32743;
  localparam logic [COUNT_W-1:0] RST_MAX_WINDOW   = 6'd10;

  typedef enum logic [REASON_W-1:0] {
    REASON_FIRST  = 3'd0,
    REASON_SOON   = 3'd1,
    REASON_MAXINT = 3'd2,
    REASON_MOVED  = 3'd3,
    REASON_TURNED = 3'd4,
    REASON_SAME   = 3'd5
  } reason_t;

  typedef struct packed {
    logic [INTV_W-1:0]  min_interval_us;
    logic [INTV_W-1:0]  max_interval_us;
    logic [DIST_W-1:0]  min_dist_sq;
    logic [COS_W-1:0]   cos_half_angle;
    logic [COUNT_W-1:0] max_window;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0]       stamp_us;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } sample_t;

  typedef struct packed {
    logic               create;
    reason_t            reason;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] window_count;
  } result_t;

endpackage

// ----- src/kfsw_in_if.sv -----
interface kfsw_in_if;
  import kfsw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAMP_W-1:0]       stamp_us;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;

  modport source (
    output valid, stamp_us, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );
  modport sink (
    input  valid, stamp_us, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

// ----- src/kfsw_out_if.sv -----
interface kfsw_out_if;
  import kfsw_pkg::*;

  logic                valid;
  logic                ready;
  logic                create_keyframe;
  logic [REASON_W-1:0] decision_reason;
  logic [INDEX_W-1:0]  keyframe_index;
  logic [COUNT_W-1:0]  window_count;

  modport source (
    output valid, create_keyframe, decision_reason, keyframe_index, window_count,
    input  ready
  );
  modport sink (
    input  valid, create_keyframe, decision_reason, keyframe_index, window_count,
    output ready
  );
endinterface

// ----- src/keyframe_selector_window_unit.sv -----
// Keyframe selector for a sliding-window pose estimator.
//
// Input channel (in_chan): one pose sample per item, a 48-bit microsecond
// stamp, a 32-bit signed position and a Q1.15 orientation quaternion.
// Result channel (out_chan): one result per sample, telling whether it became
// a keyframe, why, the index it took and the window fill after it.
// Configuration (cfg_we, cfg_index, cfg_wdata): write-only registers, taken
// at any clock edge with cfg_we high; write them only while the block is idle.
//
// An item is registered on acceptance, decided from that input register against
// the current reference, and its result is registered with the reference
// update in the same edge. The result passes through the input register and
// then the result register before it can be taken; throughput is one item
// per cycle while the receiver takes results, set by that single decision stage.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_chan.ready drops until the result is taken.
// Reset clears the reference, the index counter and the window count, and
// loads the default configuration.
module keyframe_selector_window_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  kfsw_in_if.sink                          in_chan,
  kfsw_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [kfsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfsw_pkg::CFG_W-1:0]       cfg_wdata
);
  import kfsw_pkg::*;

  cfg_t               cfg;
  logic               in_vld_r;
  sample_t            smp_r;
  logic               out_vld_r;
  result_t            res_r;
  result_t            dec;
  logic               have_ref_r;
  sample_t            ref_r;
  logic [INDEX_W-1:0] index_cnt_r;
  logic [COUNT_W-1:0] held_cnt_r;
  logic               adv;
  logic               commit;
  sample_t            in_smp;

  kfsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kfsw_decide u_decide (
    .smp       (smp_r),
    .ref_smp   (ref_r),
    .have_ref  (have_ref_r),
    .cfg       (cfg),
    .index_cnt (index_cnt_r),
    .held_cnt  (held_cnt_r),
    .res       (dec)
  );

  assign adv    = !out_vld_r || out_chan.ready;
  assign commit = in_vld_r && adv;
  assign in_chan.ready = !in_vld_r || adv;

  assign in_smp.stamp_us = in_chan.stamp_us;
  assign in_smp.pos_x    = in_chan.pos_x;
  assign in_smp.pos_y    = in_chan.pos_y;
  assign in_smp.pos_z    = in_chan.pos_z;
  assign in_smp.quat_w   = in_chan.quat_w;
  assign in_smp.quat_x   = in_chan.quat_x;
  assign in_smp.quat_y   = in_chan.quat_y;
  assign in_smp.quat_z   = in_chan.quat_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      smp_r <= in_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= dec;
    end
  end

  // The reference moves to the sample only when it becomes a keyframe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r  <= 1'b0;
      ref_r       <= '0;
      index_cnt_r <= '0;
      held_cnt_r  <= '0;
    end else if (commit && dec.create) begin
      have_ref_r  <= 1'b1;
      ref_r       <= smp_r;
      index_cnt_r <= index_cnt_r + INDEX_W'(1);
      held_cnt_r  <= dec.window_count;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.create_keyframe = res_r.create;
  assign out_chan.decision_reason = res_r.reason;
  assign out_chan.keyframe_index  = res_r.index;
  assign out_chan.window_count    = res_r.window_count;

  a_first_without_ref: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> ((dec.reason == REASON_FIRST) == !have_ref_r))
    else $error("first-sample reason does not match the reference flag");

  a_create_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (dec.create == ((dec.reason == REASON_FIRST) ||
                               (dec.reason == REASON_MAXINT) ||
                               (dec.reason == REASON_MOVED) ||
                               (dec.reason == REASON_TURNED))))
    else $error("keyframe flag disagrees with the decision reason");

  a_ref_set_after_create: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && dec.create) |=> (have_ref_r && (held_cnt_r != '0)))
    else $error("keyframe did not set the reference and window count");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r <= COUNT_W'(WINDOW_DEPTH))
    else $error("window count exceeds the window depth");

  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && dec.create) |=> (index_cnt_r == $past(index_cnt_r) + INDEX_W'(1)))
    else $error("keyframe index did not advance by one");

endmodule

// ----- src/kfsw_cfg_regs.sv -----
module kfsw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kfsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfsw_pkg::CFG_W-1:0]       cfg_wdata,
  output kfsw_pkg::cfg_t                   cfg
);
  import kfsw_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_interval_us <= RST_MIN_INTERVAL;
      cfg_r.max_interval_us <= RST_MAX_INTERVAL;
      cfg_r.min_dist_sq     <= RST_MIN_DIST_SQ;
      cfg_r.cos_half_angle  <= RST_COS_HALF;
      cfg_r.max_window      <= RST_MAX_WINDOW;
    end else if (cfg_we) begin
      // Writes to an index beyond the register list fall through and are dropped.
      unique case (cfg_index)
        CFG_MIN_INTERVAL: cfg_r.min_interval_us <= cfg_wdata[INTV_W-1:0];
        CFG_MAX_INTERVAL: cfg_r.max_interval_us <= cfg_wdata[INTV_W-1:0];
        CFG_MIN_DIST_SQ:  cfg_r.min_dist_sq     <= cfg_wdata[DIST_W-1:0];
        CFG_COS_HALF:     cfg_r.cos_half_angle  <= cfg_wdata[COS_W-1:0];
        CFG_MAX_WINDOW:   cfg_r.max_window      <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/kfsw_decide.sv -----
module kfsw_decide (
  input  kfsw_pkg::sample_t                smp,
  input  kfsw_pkg::sample_t                ref_smp,
  input  logic                             have_ref,
  input  kfsw_pkg::cfg_t                   cfg,
  input  logic [kfsw_pkg::INDEX_W-1:0]     index_cnt,
  input  logic [kfsw_pkg::COUNT_W-1:0]     held_cnt,
  output kfsw_pkg::result_t                res
);
  import kfsw_pkg::*;

  localparam int DT_W  = STAMP_W + 2;
  localparam int D_W   = POS_W + 1;
  localparam int SQ_W  = 2 * POS_W;
  localparam int D2_W  = SQ_W + 2;
  localparam int PR_W  = 2 * QUAT_W;
  localparam int DOT_W = PR_W + 2;

  logic signed [DT_W-1:0]  dt;
  logic                    too_soon;
  logic                    at_max;
  logic signed [D_W-1:0]   dx, dy, dz;
  logic [POS_W-1:0]        ax, ay, az;
  logic [SQ_W-1:0]         sqx, sqy, sqz;
  logic [D2_W-1:0]         d2;
  logic                    moved;
  logic signed [PR_W-1:0]  pw, px, py, pz;
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-2:0]        adot;
  logic                    turned;
  logic [COUNT_W-1:0]      limit;
  logic [COUNT_W:0]        held_inc;

  // Elapsed time is signed: a sample older than the reference counts as too soon.
  assign dt = $signed({2'b00, smp.stamp_us}) - $signed({2'b00, ref_smp.stamp_us});
  assign too_soon = dt < $signed({{(DT_W-INTV_W){1'b0}}, cfg.min_interval_us});
  assign at_max   = dt >= $signed({{(DT_W-INTV_W){1'b0}}, cfg.max_interval_us});

  assign dx = D_W'(smp.pos_x) - D_W'(ref_smp.pos_x);
  assign dy = D_W'(smp.pos_y) - D_W'(ref_smp.pos_y);
  assign dz = D_W'(smp.pos_z) - D_W'(ref_smp.pos_z);

  // A difference of two 32-bit values has a magnitude below 2^32.
  assign ax = dx[D_W-1] ? POS_W'(-dx) : POS_W'(dx);
  assign ay = dy[D_W-1] ? POS_W'(-dy) : POS_W'(dy);
  assign az = dz[D_W-1] ? POS_W'(-dz) : POS_W'(dz);

  assign sqx = SQ_W'(ax) * SQ_W'(ax);
  assign sqy = SQ_W'(ay) * SQ_W'(ay);
  assign sqz = SQ_W'(az) * SQ_W'(az);

  // The full-width sum compares the same as the saturated one against a 63-bit threshold.
  assign d2    = D2_W'(sqx) + D2_W'(sqy) + D2_W'(sqz);
  assign moved = d2 >= D2_W'(cfg.min_dist_sq);

  assign pw = PR_W'(smp.quat_w) * PR_W'(ref_smp.quat_w);
  assign px = PR_W'(smp.quat_x) * PR_W'(ref_smp.quat_x);
  assign py = PR_W'(smp.quat_y) * PR_W'(ref_smp.quat_y);
  assign pz = PR_W'(smp.quat_z) * PR_W'(ref_smp.quat_z);

  assign dot    = DOT_W'(pw) + DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
  assign adot   = dot[DOT_W-1] ? (DOT_W-1)'(-dot) : (DOT_W-1)'(dot);
  assign turned = adot <= (DOT_W-1)'({cfg.cos_half_angle, {QUAT_W-1{1'b0}}});

  always_comb begin
    limit = cfg.max_window;
    if (cfg.max_window == '0) begin
      limit = COUNT_W'(1);
    end else if (cfg.max_window > COUNT_W'(WINDOW_DEPTH)) begin
      limit = COUNT_W'(WINDOW_DEPTH);
    end
  end

  assign held_inc = {1'b0, held_cnt} + (COUNT_W+1)'(1);

  always_comb begin
    res.create = 1'b0;
    res.reason = REASON_SAME;
    priority if (!have_ref) begin
      res.create = 1'b1;
      res.reason = REASON_FIRST;
    end else if (too_soon) begin
      res.reason = REASON_SOON;
    end else if (at_max) begin
      res.create = 1'b1;
      res.reason = REASON_MAXINT;
    end else if (moved) begin
      res.create = 1'b1;
      res.reason = REASON_MOVED;
    end else if (turned) begin
      res.create = 1'b1;
      res.reason = REASON_TURNED;
    end else begin
      res.reason = REASON_SAME;
    end

    res.index        = res.create ? index_cnt : '0;
    res.window_count = held_cnt;
    if (res.create) begin
      res.window_count = (held_inc > {1'b0, limit}) ? limit : held_inc[COUNT_W-1:0];
    end
  end

endmodule
